[sv/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared widths, payload types and inter-stage types of the face normal unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

  localparam int COORD_BITS       = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORMAL_BITS      = NORMAL_FRAC_BITS + 2;

  localparam int EDGE_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * EDGE_BITS;
  localparam int MAG_BITS  = 2 * EDGE_BITS;
  localparam int LO_BITS   = (MAG_BITS + 1) / 2;
  localparam int HI_BITS   = MAG_BITS - LO_BITS;
  localparam int SQ_BITS   = 2 * MAG_BITS;
  localparam int SUM_BITS  = SQ_BITS + 2;
  localparam int ROOT_BITS = NORMAL_FRAC_BITS + 2;
  localparam int QUO_BITS  = NORMAL_FRAC_BITS + 1;
  localparam int JS_BITS   = SUM_BITS + ROOT_BITS;
  localparam int RES_BITS  = SUM_BITS + 2 * ROOT_BITS + 1;
  localparam int TGT_SHIFT = 2 * NORMAL_FRAC_BITS + 2;

  typedef logic signed [COORD_BITS-1:0]  coord_t;
  typedef logic signed [NORMAL_BITS-1:0] normal_t;

  typedef struct packed {
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_a_z;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_b_z;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
    coord_t vertex_c_z;
  } tfn_in_t;

  typedef struct packed {
    normal_t normal_x;
    normal_t normal_y;
    normal_t normal_z;
    logic    degenerate;
  } tfn_out_t;

  typedef struct packed {
    logic [2:0]               neg;
    logic [2:0][MAG_BITS-1:0] mag;
  } tfn_cross_t;

  typedef struct packed {
    logic                     degen;
    logic [2:0]               neg;
    logic [SUM_BITS-1:0]      sum;
    logic [2:0][RES_BITS-1:0] target;
  } tfn_norm_t;

endpackage

`default_nettype wire

[sv/tfn_cross.sv]
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors, six signed products and the cross product as sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_cross import tfn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  tfn_in_t    face,
  output logic       out_valid,
  output tfn_cross_t xprod
);

  logic signed [EDGE_BITS-1:0] e1 [3];
  logic signed [EDGE_BITS-1:0] e2 [3];
  logic signed [PROD_BITS-1:0] pa [3];
  logic signed [PROD_BITS-1:0] pb [3];
  logic signed [PROD_BITS:0]   diff [3];
  logic                        v1;
  logic                        v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1[0] <= EDGE_BITS'(face.vertex_b_x) - EDGE_BITS'(face.vertex_a_x);
      e1[1] <= EDGE_BITS'(face.vertex_b_y) - EDGE_BITS'(face.vertex_a_y);
      e1[2] <= EDGE_BITS'(face.vertex_b_z) - EDGE_BITS'(face.vertex_a_z);
      e2[0] <= EDGE_BITS'(face.vertex_c_x) - EDGE_BITS'(face.vertex_a_x);
      e2[1] <= EDGE_BITS'(face.vertex_c_y) - EDGE_BITS'(face.vertex_a_y);
      e2[2] <= EDGE_BITS'(face.vertex_c_z) - EDGE_BITS'(face.vertex_a_z);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int P = (i + 1) % 3;
    localparam int R = (i + 2) % 3;

    assign diff[i] = (PROD_BITS+1)'(pa[i]) - (PROD_BITS+1)'(pb[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        pa[i] <= PROD_BITS'(e1[P] * e2[R]);
        pb[i] <= PROD_BITS'(e1[R] * e2[P]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        xprod.neg[i] <= diff[i][PROD_BITS];
        xprod.mag[i] <= diff[i][PROD_BITS] ? MAG_BITS'(-diff[i]) : MAG_BITS'(diff[i]);
      end
    end
  end

endmodule

`default_nettype wire

[sv/tfn_square.sv]
// ----------------------------------------------------------------------------
// tfn_square
// Squares of the cross product magnitudes from split partial products, their
// sum and the per-lane targets for the root stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_square import tfn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  tfn_cross_t xprod,
  output logic       out_valid,
  output tfn_norm_t  norm
);

  logic [2*HI_BITS-1:0]       hh [3];
  logic [HI_BITS+LO_BITS-1:0] hl [3];
  logic [2*LO_BITS-1:0]       ll [3];
  logic [SQ_BITS-1:0]         sq [3];
  logic [2:0]                 neg4;
  logic [2:0]                 neg5;
  logic                       v4;
  logic                       v5;
  logic [SUM_BITS-1:0]        sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v4        <= in_valid;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [HI_BITS-1:0] hi;
    logic [LO_BITS-1:0] lo;

    assign hi = xprod.mag[i][MAG_BITS-1:LO_BITS];
    assign lo = xprod.mag[i][LO_BITS-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        hh[i] <= (2*HI_BITS)'(hi) * (2*HI_BITS)'(hi);
        hl[i] <= (HI_BITS+LO_BITS)'(hi) * (HI_BITS+LO_BITS)'(lo);
        ll[i] <= (2*LO_BITS)'(lo) * (2*LO_BITS)'(lo);
        sq[i] <= (SQ_BITS'(hh[i]) << (2*LO_BITS)) + (SQ_BITS'(hl[i]) << (LO_BITS+1))
               + SQ_BITS'(ll[i]);
      end
    end
  end

  assign sum_next = SUM_BITS'(sq[0]) + SUM_BITS'(sq[1]) + SUM_BITS'(sq[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      neg4       <= xprod.neg;
      neg5       <= neg4;
      norm.neg   <= neg5;
      norm.sum   <= sum_next;
      norm.degen <= (sum_next == '0);
      for (int i = 0; i < 3; i++) begin
        norm.target[i] <= RES_BITS'(sq[i]) << TGT_SHIFT;
      end
    end
  end

endmodule

`default_nettype wire

[sv/tfn_root.sv]
// ----------------------------------------------------------------------------
// tfn_root
// One pipeline stage per root bit: finds the largest j with j^2 * sum not
// above the target, then rounds, applies the sign (zero when degenerate) and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_root import tfn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  tfn_norm_t norm,
  output logic      out_valid,
  output tfn_out_t  result
);

  logic [RES_BITS-1:0]  rem  [ROOT_BITS][3];
  logic [JS_BITS-1:0]   js   [ROOT_BITS][3];
  logic [ROOT_BITS-1:0] root [ROOT_BITS][3];
  logic [SUM_BITS-1:0]  sum  [ROOT_BITS];
  logic [2:0]           neg  [ROOT_BITS];
  logic                 dg   [ROOT_BITS];
  logic                 vld  [ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    localparam int B = ROOT_BITS - 1 - k;
    logic                v_in;
    logic                dg_in;
    logic [2:0]          neg_in;
    logic [SUM_BITS-1:0] s_in;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign dg_in  = norm.degen;
      assign neg_in = norm.neg;
      assign s_in   = norm.sum;
    end else begin : g_next
      assign v_in   = vld[k-1];
      assign dg_in  = dg[k-1];
      assign neg_in = neg[k-1];
      assign s_in   = sum[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dg[k]  <= dg_in;
        neg[k] <= neg_in;
        sum[k] <= s_in;
      end
    end

    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [RES_BITS-1:0]  r_in;
      logic [JS_BITS-1:0]   js_in;
      logic [ROOT_BITS-1:0] j_in;
      logic [RES_BITS+1:0]  ta;
      logic [RES_BITS+1:0]  tb;
      logic [RES_BITS+1:0]  cand;

      if (k == 0) begin : g_first
        assign r_in  = norm.target[i];
        assign js_in = '0;
        assign j_in  = '0;
      end else begin : g_next
        assign r_in  = rem[k-1][i];
        assign js_in = js[k-1][i];
        assign j_in  = root[k-1][i];
      end

      assign ta   = (RES_BITS+2)'(js_in) << (B + 1);
      assign tb   = (RES_BITS+2)'(s_in) << (2 * B);
      assign cand = (RES_BITS+2)'(r_in) - ta - tb;

      always_ff @(posedge clk) begin
        if (en) begin
          if (!cand[RES_BITS+1]) begin
            rem[k][i]  <= cand[RES_BITS-1:0];
            js[k][i]   <= js_in + (JS_BITS'(s_in) << B);
            root[k][i] <= j_in | (ROOT_BITS'(1) << B);
          end else begin
            rem[k][i]  <= r_in;
            js[k][i]   <= js_in;
            root[k][i] <= j_in;
          end
        end
      end
    end
  end

  normal_t comp [3];

  for (genvar i = 0; i < 3; i++) begin : g_out
    logic [ROOT_BITS:0]  jp1;
    logic [QUO_BITS-1:0] q;

    assign jp1     = (ROOT_BITS+1)'(root[ROOT_BITS-1][i]) + (ROOT_BITS+1)'(1);
    assign q       = jp1[QUO_BITS:1];
    assign comp[i] = dg[ROOT_BITS-1] ? '0 :
                     neg[ROOT_BITS-1][i] ? -NORMAL_BITS'(q) : NORMAL_BITS'(q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[ROOT_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.normal_x   <= comp[0];
      result.normal_y   <= comp[1];
      result.normal_z   <= comp[2];
      result.degenerate <= dg[ROOT_BITS-1];
    end
  end

endmodule

`default_nettype wire

[sv/triangle_face_normal.sv]
// throughput: one triangle per cycle unless stalled; the depth is set by one stage per root bit
// in the root search, three cross product and three squaring stages and the output register
// a stall at the output holds every stage in place
// reset (synchronous) clears all valid bits; data registers are not reset
// ----------------------------------------------------------------------------
// triangle_face_normal
// Flat unit face normal of one triangle, Q4.12 vertices in, Q1.14 normal out.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_face_normal import tfn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     face_valid,
  output logic     face_ready,
  input  tfn_in_t  face,
  output logic     normal_valid,
  input  logic     normal_ready,
  output tfn_out_t normal
);

  logic       en;
  logic       cross_valid;
  tfn_cross_t xprod;
  logic       norm_valid;
  tfn_norm_t  norm;

  // whole pipeline advances unless a finished transaction is held
  assign en         = !normal_valid || normal_ready;
  assign face_ready = en;

  tfn_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (face_valid),
    .face      (face),
    .out_valid (cross_valid),
    .xprod     (xprod)
  );

  tfn_square u_square (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cross_valid),
    .xprod     (xprod),
    .out_valid (norm_valid),
    .norm      (norm)
  );

  tfn_root u_root (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (norm_valid),
    .norm      (norm),
    .out_valid (normal_valid),
    .result    (normal)
  );

endmodule

`default_nettype wire
